[hw/rtl/mbm_pkg.sv]
// Shared types, codes and CRC helper for the Modbus RTU master frame engine.
package mbm_pkg;

  localparam int MaxFrame = 256;
  localparam int BcntW    = $clog2(MaxFrame + 1);
  localparam int ReqLen   = 6;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  localparam logic [7:0] FcReadHolding = 8'h03;
  localparam logic [7:0] FcReadInput   = 8'h04;
  localparam logic [7:0] FcWriteSingle = 8'h06;

  localparam logic [1:0] ReqHolding = 2'd0;
  localparam logic [1:0] ReqInput   = 2'd1;
  localparam logic [1:0] ReqWrite   = 2'd2;
  localparam logic [1:0] ReqBad     = 2'd3;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StTimeout  = 3'd1;
  localparam logic [2:0] StCrc      = 3'd2;
  localparam logic [2:0] StMismatch = 3'd3;
  localparam logic [2:0] StFewWords = 3'd4;

  typedef enum logic [1:0] {
    OpStart  = 2'd0,
    OpRxByte = 2'd1,
    OpEof    = 2'd2,
    OpTick   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ResTx     = 2'd0,
    ResWord   = 2'd1,
    ResStatus = 2'd2,
    ResNone   = 2'd3
  } res_kind_t;

  typedef struct packed {
    logic                   is_run;
    res_kind_t              kind;
    logic [2:0]             status;
    logic [6:0]             word_index;
    logic [15:0]            word_value;
    logic [ReqLen-1:0][7:0] req_bytes;
  } res_t;

  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[hw/rtl/mbm_core.sv]
// Input register, exchange state and per-word decode of the frame engine.
module mbm_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_opcode,
  input  logic [7:0]         in_slave_id,
  input  logic [1:0]         in_request_kind,
  input  logic [15:0]        in_register_address,
  input  logic [15:0]        in_quantity_or_value,
  input  logic [7:0]         in_rx_byte,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_response_timeout_ms,
  input  logic               sink_free,
  output logic               res_load,
  output mbm_pkg::res_t      res
);
  import mbm_pkg::*;

  // input register
  logic        s1_valid_r;
  opcode_t     s1_op_r;
  logic [7:0]  s1_id_r;
  logic [1:0]  s1_kind_r;
  logic [15:0] s1_addr_r;
  logic [15:0] s1_qv_r;
  logic [7:0]  s1_rx_r;

  // exchange state
  logic [ReqLen-1:0][7:0] req_r, req_nxt;
  logic                   waiting_r, waiting_nxt;
  logic [BcntW-1:0]       bcnt_r, bcnt_nxt;
  logic [15:0]            crc_r, crc_nxt;
  logic [2:0][7:0]        win_r, win_nxt;
  logic                   mis_r, mis_nxt;
  logic [7:0]             words_r, words_nxt;
  logic [15:0]            ticks_r, ticks_nxt;
  logic [15:0]            tmo_r;

  logic        step;
  logic        has_res;
  logic        is_write;
  logic [15:0] qty;
  logic        drop;
  logic        emit_word;
  logic [15:0] ticks_inc;
  logic [7:0]  fc;

  assign cfg_ready = 1'b1;
  assign is_write  = (req_r[1] == FcWriteSingle);
  assign qty       = {req_r[4], req_r[5]};
  assign drop      = (bcnt_r >= BcntW'(MaxFrame));
  assign emit_word = !is_write && (bcnt_r >= BcntW'(ReqLen)) && !bcnt_r[0] &&
                     ({8'h00, words_r} < qty);
  assign ticks_inc = ticks_r + 16'd1;

  always_comb begin
    case (s1_kind_r)
      ReqHolding: fc = FcReadHolding;
      ReqInput:   fc = FcReadInput;
      default:    fc = FcWriteSingle;
    endcase
  end

  always_comb begin
    req_nxt     = req_r;
    waiting_nxt = waiting_r;
    bcnt_nxt    = bcnt_r;
    crc_nxt     = crc_r;
    win_nxt     = win_r;
    mis_nxt     = mis_r;
    words_nxt   = words_r;
    ticks_nxt   = ticks_r;
    has_res     = 1'b0;
    res         = '0;
    res.kind    = ResNone;
    case (s1_op_r)
      OpStart: begin
        if (s1_kind_r != ReqBad) begin
          req_nxt     = {s1_qv_r[7:0], s1_qv_r[15:8], s1_addr_r[7:0],
                         s1_addr_r[15:8], fc, s1_id_r};
          waiting_nxt = 1'b1;
          bcnt_nxt    = '0;
          crc_nxt     = CrcInit;
          win_nxt     = '0;
          mis_nxt     = 1'b0;
          words_nxt   = '0;
          ticks_nxt   = '0;
          has_res       = 1'b1;
          res.is_run    = 1'b1;
          res.kind      = ResTx;
          res.req_bytes = req_nxt;
        end
      end
      OpRxByte: begin
        if (waiting_r && !drop) begin
          if (bcnt_r < BcntW'(ReqLen) && s1_rx_r != req_r[bcnt_r[2:0]] &&
              (is_write || bcnt_r < BcntW'(2))) begin
            mis_nxt = 1'b1;
          end
          if (emit_word) begin
            has_res        = 1'b1;
            res.kind       = ResWord;
            res.word_index = words_r[6:0];
            res.word_value = {win_r[0], win_r[1]};
            words_nxt      = words_r + 8'd1;
          end
          win_nxt  = {s1_rx_r, win_r[2], win_r[1]};
          crc_nxt  = crc16_byte(crc_r, s1_rx_r);
          bcnt_nxt = bcnt_r + BcntW'(1);
        end
      end
      OpEof: begin
        if (waiting_r) begin
          has_res     = 1'b1;
          res.kind    = ResStatus;
          waiting_nxt = 1'b0;
          if (bcnt_r < BcntW'(5)) begin
            res.status = StTimeout;
          end else if (crc_r != 16'h0000) begin
            res.status = StCrc;
          end else if (mis_r || (is_write && bcnt_r < BcntW'(8))) begin
            res.status = StMismatch;
          end else if (!is_write && ({8'h00, words_r} < qty)) begin
            res.status = StFewWords;
          end else begin
            res.status = StOk;
          end
        end
      end
      default: begin
        if (waiting_r) begin
          ticks_nxt = ticks_inc;
          if (ticks_inc >= tmo_r) begin
            has_res     = 1'b1;
            res.kind    = ResStatus;
            res.status  = StTimeout;
            waiting_nxt = 1'b0;
          end
        end
      end
    endcase
  end

  assign step     = s1_valid_r && (!has_res || sink_free);
  assign in_ready = !s1_valid_r || step;
  assign res_load = step && has_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r   <= opcode_t'(in_opcode);
      s1_id_r   <= in_slave_id;
      s1_kind_r <= in_request_kind;
      s1_addr_r <= in_register_address;
      s1_qv_r   <= in_quantity_or_value;
      s1_rx_r   <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      req_r <= req_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waiting_r <= 1'b0;
      bcnt_r    <= '0;
      crc_r     <= CrcInit;
      win_r     <= '0;
      mis_r     <= 1'b0;
      words_r   <= '0;
      ticks_r   <= '0;
    end else if (step) begin
      waiting_r <= waiting_nxt;
      bcnt_r    <= bcnt_nxt;
      crc_r     <= crc_nxt;
      win_r     <= win_nxt;
      mis_r     <= mis_nxt;
      words_r   <= words_nxt;
      ticks_r   <= ticks_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmo_r <= 16'd1000;
    end else if (cfg_valid && cfg_ready) begin
      tmo_r <= cfg_response_timeout_ms;
    end
  end

  a_bcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bcnt_r <= BcntW'(MaxFrame))
    else $error("receive count past frame limit");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && s1_op_r == OpStart && s1_kind_r != ReqBad |=>
      waiting_r && bcnt_r == '0 && crc_r == CrcInit && words_r == '0)
    else $error("start did not open a clean exchange");

  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    step && !waiting_r && s1_op_r != OpStart |=> $stable(crc_r) && $stable(bcnt_r))
    else $error("idle event changed receive state");

  a_load_gated: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> sink_free)
    else $error("result loaded into busy output stage");

endmodule

[hw/rtl/mbm_txser.sv]
// Output stage: holds one word or status result or sends an eight-byte request run with its CRC.
module mbm_txser (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          ld,
  input  mbm_pkg::res_t res,
  output logic          free,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_result_kind,
  output logic [7:0]    out_tx_byte,
  output logic [6:0]    out_word_index,
  output logic [15:0]   out_word_value,
  output logic [2:0]    out_status,
  output logic          out_last
);
  import mbm_pkg::*;

  logic                   busy_r;
  logic                   is_run_r;
  logic [2:0]             idx_r;
  logic [ReqLen-1:0][7:0] bytes_r;
  logic [15:0]            crc_r;
  res_kind_t              kind_r;
  logic [2:0]             status_r;
  logic [6:0]             windex_r;
  logic [15:0]            wvalue_r;

  logic fire;
  logic done_fire;
  logic in_body;

  assign in_body   = (idx_r < 3'(ReqLen));
  assign fire      = busy_r && out_ready;
  assign done_fire = fire && (!is_run_r || idx_r == 3'd7);
  assign free      = !busy_r || done_fire;

  assign out_valid       = busy_r;
  assign out_result_kind = is_run_r ? ResTx : kind_r;
  assign out_tx_byte     = !is_run_r ? 8'h00 :
                           in_body ? bytes_r[0] :
                           (idx_r == 3'd6) ? crc_r[7:0] : crc_r[15:8];
  assign out_word_index  = is_run_r ? 7'd0 : windex_r;
  assign out_word_value  = is_run_r ? 16'd0 : wvalue_r;
  assign out_status      = is_run_r ? 3'd0 : status_r;
  assign out_last        = is_run_r && idx_r == 3'd7;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (ld) begin
      busy_r <= 1'b1;
    end else if (done_fire) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      is_run_r <= res.is_run;
      idx_r    <= '0;
      bytes_r  <= res.req_bytes;
      crc_r    <= CrcInit;
      kind_r   <= res.kind;
      status_r <= res.status;
      windex_r <= res.word_index;
      wvalue_r <= res.word_value;
    end else if (fire && is_run_r) begin
      idx_r <= idx_r + 3'd1;
      if (in_body) begin
        bytes_r <= {8'h00, bytes_r[ReqLen-1:1]};
        crc_r   <= crc16_byte(crc_r, bytes_r[0]);
      end
    end
  end

  a_ld_free: assert property (@(posedge clk) disable iff (!rst_n)
    ld |-> free)
    else $error("load while output stage holds a word");

  a_single_idx: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !is_run_r |-> idx_r == 3'd0)
    else $error("single result with run index");

  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && is_run_r && idx_r == 3'd7 && out_ready && !ld |=> !busy_r)
    else $error("run did not end after last byte");

endmodule

[hw/rtl/modbus_rtu_master_frame_engine.sv]
// Top level of the Modbus RTU master frame engine.
// A result is registered in the core's input register and then in the output stage.
// Throughput: one input word per cycle, except that an input with a result waits
// while the one-byte output stage is busy, such as with a start request's byte run.
// The request CRC advances one byte per sent request body byte in the output stage.
// Reset (rst_n low, synchronous): idle, timeout 1000 ticks, receive CRC 0xFFFF.
module modbus_rtu_master_frame_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_slave_id,
  input  logic [1:0]  in_request_kind,
  input  logic [15:0] in_register_address,
  input  logic [15:0] in_quantity_or_value,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_kind,
  output logic [7:0]  out_tx_byte,
  output logic [6:0]  out_word_index,
  output logic [15:0] out_word_value,
  output logic [2:0]  out_status,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_response_timeout_ms
);
  import mbm_pkg::*;

  res_t res;
  logic res_load;
  logic sink_free;

  mbm_core u_core (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_opcode               (in_opcode),
    .in_slave_id             (in_slave_id),
    .in_request_kind         (in_request_kind),
    .in_register_address     (in_register_address),
    .in_quantity_or_value    (in_quantity_or_value),
    .in_rx_byte              (in_rx_byte),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_response_timeout_ms (cfg_response_timeout_ms),
    .sink_free               (sink_free),
    .res_load                (res_load),
    .res                     (res)
  );

  mbm_txser u_txser (
    .clk             (clk),
    .rst_n           (rst_n),
    .ld              (res_load),
    .res             (res),
    .free            (sink_free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_tx_byte     (out_tx_byte),
    .out_word_index  (out_word_index),
    .out_word_value  (out_word_value),
    .out_status      (out_status),
    .out_last        (out_last)
  );

endmodule
